[hdl/round_robin_process_scheduler_unit_assert.svh]
// assertion macros used by the scheduler rtl
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define RRPS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// next-cycle implication, disabled while reset is high
`define RRPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

[hdl/rrps_pkg.sv]
// types and constants of the round-robin process scheduler
package rrps_pkg;

  localparam int PTR_BITS = 32;
  localparam int ID_BITS  = 4;

  localparam logic MODE_CREATE = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [PTR_BITS-1:0] stack_pointer;
    logic                current_blocked;
  } in_item_t;

  typedef struct packed {
    logic [PTR_BITS-1:0] next_stack_pointer;
    logic [ID_BITS-1:0]  next_process_id;
    logic                status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RING_RD,
    S_SP_RD,
    S_OUT
  } state_t;

endpackage

[hdl/round_robin_process_scheduler_unit.sv]
// round-robin process scheduler: slot table, ready ring and control
//
// Usage: drive cmd and raise start while busy is low; the item is taken at
// that edge. mode create takes the lowest free slot, stores the stack
// pointer and queues the slot; mode select saves/requeues or frees the
// running process and hands out the head of the ready ring.
// Exactly one result per item appears on result with done high for one
// cycle; the receiver cannot stall it. done comes in the first idle cycle,
// so a new start may be given in that very cycle.
// Response: a create with a zero pointer answers in the cycle after acceptance;
// any other create waits on the free-slot scan, which checks a group of up to
// 16 slots a cycle and stops at the first group with a free slot or at the
// last group; a select waits on the two dependent reads (ready ring, then
// pointer table), each a registered ram read, and ends after the ring read
// when the ring is empty. Items are handled one at a time.
// Reset (rst, synchronous) empties the ring, frees all slots and clears the
// running process; ring and pointer rams need no clearing since an entry is
// only read after it has been written.
module round_robin_process_scheduler_unit #(
  parameter int MAX_PROCESSES = 16,
  parameter int POINTER_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rrps_pkg::in_item_t  cmd,
  output logic                done,
  output rrps_pkg::out_item_t result
);

  import rrps_pkg::*;

  `include "round_robin_process_scheduler_unit_assert.svh"

  localparam int SP_W   = (POINTER_WIDTH < PTR_BITS) ? POINTER_WIDTH : PTR_BITS;
  localparam int SLOT_W = $clog2(MAX_PROCESSES);
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int GRP_W  = (MAX_PROCESSES < 16) ? MAX_PROCESSES : 16;
  localparam int NGRP   = (MAX_PROCESSES + GRP_W - 1) / GRP_W;
  localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int OFF_W  = $clog2(GRP_W);

  state_t state, state_next;

  logic [SLOT_W-1:0]        head;
  logic [CNT_W-1:0]         count;
  logic [MAX_PROCESSES-1:0] slot_in_use;
  logic [SLOT_W-1:0]        current_slot;
  logic                     current_valid;
  logic [GIDX_W-1:0]        grp;
  logic [SP_W-1:0]          sp_q;
  logic                     done_q;
  out_item_t                result_q;

  logic                     accept;
  logic [SP_W-1:0]          cmd_sp;
  logic                     cmd_sp_zero;
  logic [SLOT_W:0]          tail_sum;
  logic [SLOT_W-1:0]        tail;
  logic                     ring_full;
  logic                     last_grp;

  logic [NGRP*GRP_W-1:0]    in_use_pad;
  logic [GRP_W-1:0]         chunk;
  logic                     hit;
  logic [OFF_W-1:0]         hit_off;
  logic [SLOT_W-1:0]        hit_slot;

  // ram ports and per-cycle controls
  logic                     ring_we;
  logic [SLOT_W-1:0]        ring_waddr;
  logic [SLOT_W-1:0]        ring_wdata;
  logic [SLOT_W-1:0]        ring_rdata;
  logic                     sp_we;
  logic [SLOT_W-1:0]        sp_waddr;
  logic [SP_W-1:0]          sp_wdata;
  logic [SP_W-1:0]          sp_rdata;
  logic                     push;
  logic                     pop;
  logic                     claim;
  logic                     release_cur;
  logic                     emit;
  out_item_t                emit_item;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign done   = done_q;
  assign result = result_q;

  assign cmd_sp      = SP_W'(cmd.stack_pointer);
  assign cmd_sp_zero = (cmd_sp == '0);

  // tail slot of the ring, head + count wrapped once
  assign tail_sum  = (SLOT_W+1)'(head) + (SLOT_W+1)'(count);
  assign tail      = (tail_sum >= (SLOT_W+1)'(MAX_PROCESSES)) ?
                     SLOT_W'(tail_sum - (SLOT_W+1)'(MAX_PROCESSES)) : SLOT_W'(tail_sum);
  assign ring_full = (count == CNT_W'(MAX_PROCESSES));
  assign last_grp  = (grp == GIDX_W'(NGRP - 1));

  // free-slot scan: one group of slots per cycle, padding counts as taken
  always_comb begin
    in_use_pad = '1;
    in_use_pad[MAX_PROCESSES-1:0] = slot_in_use;
  end

  assign chunk = in_use_pad[int'(grp)*GRP_W +: GRP_W];

  always_comb begin
    hit     = 1'b0;
    hit_off = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (!chunk[i]) begin
        hit     = 1'b1;
        hit_off = OFF_W'(i);
      end
    end
  end

  assign hit_slot = SLOT_W'(int'(grp) * GRP_W + int'(hit_off));

  rrps_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_PROCESSES)
  ) u_ready_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (head),
    .rdata (ring_rdata)
  );

  // read address is the slot just read from the ring
  rrps_ram #(
    .WIDTH (SP_W),
    .DEPTH (MAX_PROCESSES)
  ) u_saved_sp (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .raddr (ring_rdata),
    .rdata (sp_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.mode == MODE_SELECT) begin
            state_next = S_RING_RD;
          end else if (!cmd_sp_zero) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit || last_grp) begin
          state_next = S_IDLE;
        end
      end
      S_RING_RD: begin
        state_next = (count == '0) ? S_IDLE : S_SP_RD;
      end
      S_SP_RD: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ring_we     = 1'b0;
    ring_waddr  = tail;
    ring_wdata  = current_slot;
    sp_we       = 1'b0;
    sp_waddr    = current_slot;
    sp_wdata    = cmd_sp;
    push        = 1'b0;
    pop         = 1'b0;
    claim       = 1'b0;
    release_cur = 1'b0;
    emit        = 1'b0;
    emit_item   = '{next_stack_pointer: '0, next_process_id: '0, status: STATUS_FAIL};
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.mode == MODE_SELECT) begin
            // settle the running process before picking the next one
            if (current_valid) begin
              if (!cmd_sp_zero) begin
                sp_we = 1'b1;
                if (!cmd.current_blocked && !ring_full) begin
                  ring_we = 1'b1;
                  push    = 1'b1;
                end
              end else begin
                release_cur = 1'b1;
              end
            end
          end else if (cmd_sp_zero) begin
            emit = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          claim      = 1'b1;
          sp_we      = 1'b1;
          sp_waddr   = hit_slot;
          sp_wdata   = sp_q;
          ring_wdata = hit_slot;
          if (!ring_full) begin
            ring_we = 1'b1;
            push    = 1'b1;
          end
          emit      = 1'b1;
          emit_item = '{next_stack_pointer: '0, next_process_id: ID_BITS'(hit_slot),
                        status: STATUS_OK};
        end else if (last_grp) begin
          emit = 1'b1;
        end
      end
      S_RING_RD: begin
        if (count == '0) begin
          emit = 1'b1;
        end
      end
      S_SP_RD: begin
        pop = 1'b1;
      end
      S_OUT: begin
        emit      = 1'b1;
        emit_item = '{next_stack_pointer: PTR_BITS'(sp_rdata),
                      next_process_id: ID_BITS'(current_slot), status: STATUS_OK};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      count         <= '0;
      slot_in_use   <= '0;
      current_slot  <= '0;
      current_valid <= 1'b0;
      grp           <= '0;
      done_q        <= 1'b0;
    end else begin
      state  <= state_next;
      done_q <= emit;
      if (accept) begin
        grp <= '0;
      end else if (state == S_SCAN && !hit && !last_grp) begin
        grp <= grp + GIDX_W'(1);
      end
      if (push) begin
        count <= count + CNT_W'(1);
      end else if (pop) begin
        count <= count - CNT_W'(1);
      end
      if (pop) begin
        head          <= (head == SLOT_W'(MAX_PROCESSES - 1)) ? '0 : head + SLOT_W'(1);
        current_slot  <= ring_rdata;
        current_valid <= 1'b1;
      end else if (state == S_RING_RD && count == '0) begin
        current_valid <= 1'b0;
      end
      if (claim) begin
        slot_in_use[hit_slot] <= 1'b1;
      end else if (release_cur) begin
        slot_in_use[current_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sp_q <= cmd_sp;
    end
    if (emit) begin
      result_q <= emit_item;
    end
  end

  `RRPS_ASSERT_NOW(a_done_when_idle, clk, rst, done, !busy)
  `RRPS_ASSERT_NOW(a_count_bounded, clk, rst, 1'b1, count <= CNT_W'(MAX_PROCESSES))
  `RRPS_ASSERT_NOW(a_ring_in_use, clk, rst, 1'b1, int'(count) <= $countones(slot_in_use))
  `RRPS_ASSERT_NEXT(a_accept_busy, clk, rst,
                    accept && !(cmd.mode == MODE_CREATE && cmd_sp_zero), busy && !done)

endmodule

[hdl/rrps_ram.sv]
// generic single-write, single-read ram with registered read data
module rrps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[bench/tb_round_robin_process_scheduler_unit.sv]
// self-checking testbench for the round-robin process scheduler
module tb_round_robin_process_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rrps_pkg::*;

  localparam int SLOTS      = 16;
  localparam int STALL_MAX  = 1000;
  localparam int TAIL_WAIT  = 8;
  localparam int MAX_BLOCKS = 10;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  cmd;
  logic      done;
  out_item_t result;

  round_robin_process_scheduler_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // scheduler state as predicted from accepted items
  logic [3:0]          ready_ring [SLOTS];
  logic [3:0]          ring_head;
  logic [4:0]          ring_count;
  logic [PTR_BITS-1:0] saved_sp [SLOTS];
  bit                  slot_taken [SLOTS];
  logic [3:0]          run_slot;
  bit                  run_valid;
  int                  blocked_total;

  out_item_t dispatch_q[$];
  int        mismatches;
  int        stall_cycles;

  function automatic void ring_append(logic [3:0] slot);
    if (ring_count < 5'(SLOTS)) begin
      ready_ring[4'(ring_head + ring_count[3:0])] = slot;
      ring_count++;
    end
  endfunction

  function automatic out_item_t next_dispatch(in_item_t it);
    out_item_t  r;
    logic [3:0] slot;
    bit         found;
    r = '0;
    r.status = STATUS_OK;
    if (it.mode == MODE_CREATE) begin
      found = 1'b0;
      slot = '0;
      // scan downward so the lowest free slot wins
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_taken[i]) begin
          slot = 4'(i);
          found = 1'b1;
        end
      end
      if (it.stack_pointer == '0 || !found) begin
        r.status = STATUS_FAIL;
      end else begin
        slot_taken[slot] = 1'b1;
        saved_sp[slot] = it.stack_pointer;
        ring_append(slot);
        r.next_process_id = slot;
      end
    end else begin
      if (run_valid) begin
        if (it.stack_pointer != '0) begin
          saved_sp[run_slot] = it.stack_pointer;
          if (!it.current_blocked) ring_append(run_slot);
          else blocked_total++;
        end else begin
          slot_taken[run_slot] = 1'b0;
        end
      end
      if (ring_count == '0) begin
        run_valid = 1'b0;
        r.status = STATUS_FAIL;
      end else begin
        run_slot = ready_ring[ring_head];
        ring_head++;
        ring_count--;
        run_valid = 1'b1;
        r.next_stack_pointer = saved_sp[run_slot];
        r.next_process_id = run_slot;
      end
    end
    return r;
  endfunction

  function automatic logic [PTR_BITS-1:0] random_pointer();
    logic [PTR_BITS-1:0] p;
    case ($urandom_range(3))
      0, 1: p = $urandom;
      2: p = PTR_BITS'($urandom_range(255, 1));
      default: p = '1 - PTR_BITS'($urandom_range(255));
    endcase
    return p;
  endfunction

  // mostly well-formed traffic: creates, mostly while slots are free, selects that
  // requeue or finish the running process, rare blocks and zero-pointer creates
  function automatic in_item_t random_item();
    in_item_t it;
    int       free_slots;
    int       roll;
    free_slots = 0;
    foreach (slot_taken[i]) if (!slot_taken[i]) free_slots++;
    roll = $urandom_range(99);
    it.current_blocked = 1'($urandom_range(1));
    it.stack_pointer = random_pointer();
    if (roll < 3) begin
      it.mode = MODE_CREATE;
      it.stack_pointer = '0;
    end else if (roll < (free_slots > 0 ? 38 : 10)) begin
      it.mode = MODE_CREATE;
    end else begin
      it.mode = MODE_SELECT;
      if (run_valid) begin
        if ($urandom_range(99) < 40) it.stack_pointer = '0;
        it.current_blocked = (blocked_total < MAX_BLOCKS && $urandom_range(99) < 4);
      end
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(3) == 0) begin
      gap = $urandom_range(4, 1);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    dispatch_q.push_back(next_dispatch(it));
  endtask

  task automatic send_fields(logic mode, logic [PTR_BITS-1:0] sp, logic blocked);
    in_item_t it;
    it.mode = mode;
    it.stack_pointer = sp;
    it.current_blocked = blocked;
    send_item(it, 1'b0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (dispatch_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic note_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected sp=%h id=%0d st=%0d, got sp=%h id=%0d st=%0d",
               $realtime, what, want.next_stack_pointer, want.next_process_id,
               want.status, got.next_stack_pointer, got.next_process_id, got.status);
  endtask

  // select with nothing running and nothing queued, blocked bit ignored
  task automatic test_empty_select();
    send_fields(MODE_SELECT, '1, 1'b1);
    send_fields(MODE_SELECT, '0, 1'b0);
  endtask

  // zero-pointer create, fill every slot, then create into a full table
  task automatic test_create_limits();
    logic [PTR_BITS-1:0] sp;
    send_fields(MODE_CREATE, '0, 1'b1);
    for (int i = 0; i < SLOTS; i++) begin
      case (i)
        0: sp = '1;
        1: sp = 32'h0000_0001;
        2: sp = 32'h8000_0000;
        3: sp = 32'h5555_5555;
        4: sp = 32'hAAAA_AAAA;
        default: sp = $urandom | 32'h1;
      endcase
      send_fields(MODE_CREATE, sp, 1'(i & 1));
    end
    send_fields(MODE_CREATE, 32'hDEAD_BEEF, 1'b0);
  endtask

  // first select with nothing running, requeue, block, finish, reuse a freed slot
  task automatic test_select_cases();
    send_fields(MODE_SELECT, $urandom | 32'h1, 1'b1);
    send_fields(MODE_SELECT, 32'h1234_5678, 1'b0);
    send_fields(MODE_SELECT, 32'hFEDC_BA98, 1'b1);
    send_fields(MODE_SELECT, '0, 1'b0);
    send_fields(MODE_CREATE, 32'h0BAD_F00D, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 900; n++) begin
      send_item(random_item(), 1'b1);
      // hold the sender off until the scheduler has drained
      if (n == 450) wait_idle();
    end
  endtask

  task automatic test_back_to_back();
    for (int n = 0; n < 125; n++) send_item(random_item(), 1'b0);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (dispatch_q.size() == 0) begin
        note_mismatch("unexpected result", '0, result);
      end else begin
        want = dispatch_q.pop_front();
        if (result.next_stack_pointer !== want.next_stack_pointer
            || result.next_process_id !== want.next_process_id
            || result.status !== want.status)
          note_mismatch("result mismatch", want, result);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    mismatches = 0;
    stall_cycles = 0;
    ring_head = '0;
    ring_count = '0;
    run_slot = '0;
    run_valid = 1'b0;
    blocked_total = 0;
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_select();
    test_create_limits();
    test_select_cases();
    test_random_traffic();
    test_back_to_back();
    wait_idle();

    if (dispatch_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/rrps_pkg.sv
hdl/rrps_ram.sv
hdl/round_robin_process_scheduler_unit.sv
bench/tb_round_robin_process_scheduler_unit.sv
